FILE: hdl/lmsd_pkg.sv
package lmsd_pkg;

  // Default matrix side length
  localparam int SIDE_DEFAULT = 8;

  // Fixed field widths
  localparam int COORD_W = 3;
  localparam int OP_W    = 3;
  localparam int PIN_W   = 8;
  localparam int DWELL_W = 8;
  localparam int ROT_W   = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET_PIXEL = 3'd0;
  localparam logic [OP_W-1:0] OP_RECT      = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_ALL  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [OP_W-1:0] OP_INVERT    = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd5;

  // Rotation modes
  localparam logic [ROT_W-1:0] ROT_NONE    = 2'd0;
  localparam logic [ROT_W-1:0] ROT_QUARTER = 2'd1;
  localparam logic [ROT_W-1:0] ROT_HALF    = 2'd2;
  localparam logic [ROT_W-1:0] ROT_THREEQ  = 2'd3;

  // Register indexes on the configuration port
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION_MODE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_DWELL      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_ENABLE = 2'd3;

  // One registered drawing item handed to the frame buffer
  typedef struct packed {
    logic               valid;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
    logic               pixel_value;
    logic               filled;
  } draw_cmd_t;

endpackage

FILE: hdl/lmsd_fbuf.sv
module lmsd_fbuf #(
  parameter int SIDE = lmsd_pkg::SIDE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  lmsd_pkg::draw_cmd_t cmd,
  output logic [SIDE-1:0]     rows_next [SIDE]
);

  logic [SIDE-1:0]              rows [SIDE];
  logic [SIDE-1:0]              hit  [SIDE];
  logic [lmsd_pkg::COORD_W-1:0] x0, x1, y0, y1;
  logic                         in_y, edge_y, in_x, side_x;

  // Order the corners and build the pixel hit mask of the item
  always_comb begin
    x0 = (cmd.first_x < cmd.last_x) ? cmd.first_x : cmd.last_x;
    x1 = (cmd.first_x < cmd.last_x) ? cmd.last_x  : cmd.first_x;
    y0 = (cmd.first_y < cmd.last_y) ? cmd.first_y : cmd.last_y;
    y1 = (cmd.first_y < cmd.last_y) ? cmd.last_y  : cmd.first_y;
    in_y   = 1'b0;
    edge_y = 1'b0;
    in_x   = 1'b0;
    side_x = 1'b0;
    for (int r = 0; r < SIDE; r++) begin
      in_y   = (r >= int'(y0)) && (r <= int'(y1));
      edge_y = (r == int'(y0)) || (r == int'(y1));
      for (int c = 0; c < SIDE; c++) begin
        in_x   = (c >= int'(x0)) && (c <= int'(x1));
        side_x = (c == int'(x0)) || (c == int'(x1));
        if (cmd.operation == lmsd_pkg::OP_SET_PIXEL) begin
          hit[r][c] = (r == int'(cmd.first_y)) && (c == int'(cmd.first_x));
        end else begin
          hit[r][c] = in_y && in_x && (cmd.filled || edge_y || side_x);
        end
      end
    end
  end

  // Apply the operation to every row in parallel
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      rows_next[r] = rows[r];
      if (cmd.valid) begin
        case (cmd.operation)
          lmsd_pkg::OP_SET_PIXEL,
          lmsd_pkg::OP_RECT: begin
            rows_next[r] = cmd.pixel_value ? (rows[r] | hit[r]) : (rows[r] & ~hit[r]);
          end
          lmsd_pkg::OP_FILL_ALL:  rows_next[r] = '1;
          lmsd_pkg::OP_CLEAR_ALL: rows_next[r] = '0;
          lmsd_pkg::OP_INVERT:    rows_next[r] = ~rows[r];
          default:                rows_next[r] = rows[r];
        endcase
      end
    end
  end

  // Hold the buffer; reset clears every pixel
  always_ff @(posedge clk) begin
    for (int r = 0; r < SIDE; r++) begin
      if (rst) begin
        rows[r] <= '0;
      end else begin
        rows[r] <= rows_next[r];
      end
    end
  end

endmodule

FILE: hdl/led_matrix_scan_driver_unit.sv
// Each item is registered at start, then its pins and done are registered from the updated buffer.
// Throughput: one item per cycle; busy stays low, so start may be held every cycle.
// Each result is on select_pins/drive_pins for exactly one cycle with done high;
// the receiver cannot stall and must take it then.
// Reset clears the frame buffer, scan line and dwell count and loads the register
// reset values (active level 1, no rotation, dwell 1, display off).
module led_matrix_scan_driver_unit #(
  parameter int SIDE = lmsd_pkg::SIDE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [lmsd_pkg::OP_W-1:0]      operation,
  input  logic [lmsd_pkg::COORD_W-1:0]   first_x,
  input  logic [lmsd_pkg::COORD_W-1:0]   first_y,
  input  logic [lmsd_pkg::COORD_W-1:0]   last_x,
  input  logic [lmsd_pkg::COORD_W-1:0]   last_y,
  input  logic                           pixel_value,
  input  logic                           filled,
  output logic                           done,
  output logic [lmsd_pkg::PIN_W-1:0]     select_pins,
  output logic [lmsd_pkg::PIN_W-1:0]     drive_pins,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int LINE_W = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(SIDE - 1);

  // Configuration registers
  logic                          active_level;
  logic [lmsd_pkg::ROT_W-1:0]    rotation_mode;
  logic [lmsd_pkg::DWELL_W-1:0]  row_dwell;
  logic                          display_enable;

  // Input register and scan state
  lmsd_pkg::draw_cmd_t           cmd;
  logic [LINE_W-1:0]             scan_line, scan_line_next;
  logic [lmsd_pkg::DWELL_W-1:0]  dwell_count, dwell_count_next;
  logic [lmsd_pkg::DWELL_W:0]    dwell_sum;
  logic [lmsd_pkg::DWELL_W-1:0]  dwell_eff;

  // Pin generation
  logic [SIDE-1:0]               rows_next [SIDE];
  logic [SIDE-1:0]               row_sel;
  logic [LINE_W-1:0]             far_line, row_addr;
  logic [lmsd_pkg::PIN_W-1:0]    sel_next, drv_next;

  logic                          wr_en;
  logic [lmsd_pkg::REG_IDX_W-1:0] reg_idx;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration write and read-back
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level   <= 1'b1;
      rotation_mode  <= lmsd_pkg::ROT_NONE;
      row_dwell      <= lmsd_pkg::DWELL_W'(1);
      display_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        lmsd_pkg::REG_ACTIVE_LEVEL:   active_level   <= pwdata[0];
        lmsd_pkg::REG_ROTATION_MODE:  rotation_mode  <= pwdata[lmsd_pkg::ROT_W-1:0];
        lmsd_pkg::REG_ROW_DWELL:      row_dwell      <= pwdata[lmsd_pkg::DWELL_W-1:0];
        lmsd_pkg::REG_DISPLAY_ENABLE: display_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lmsd_pkg::REG_ACTIVE_LEVEL:   prdata = {31'd0, active_level};
      lmsd_pkg::REG_ROTATION_MODE:  prdata = {30'd0, rotation_mode};
      lmsd_pkg::REG_ROW_DWELL:      prdata = {24'd0, row_dwell};
      lmsd_pkg::REG_DISPLAY_ENABLE: prdata = {31'd0, display_enable};
      default:                      prdata = '0;
    endcase
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid <= start;
    end
    cmd.operation   <= operation;
    cmd.first_x     <= first_x;
    cmd.first_y     <= first_y;
    cmd.last_x      <= last_x;
    cmd.last_y      <= last_y;
    cmd.pixel_value <= pixel_value;
    cmd.filled      <= filled;
  end

  lmsd_fbuf #(
    .SIDE(SIDE)
  ) u_fbuf (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rows_next(rows_next)
  );

  // Advance the scan on enabled ticks
  always_comb begin
    dwell_eff        = (row_dwell == '0) ? lmsd_pkg::DWELL_W'(1) : row_dwell;
    dwell_sum        = {1'b0, dwell_count} + 1'b1;
    scan_line_next   = scan_line;
    dwell_count_next = dwell_count;
    if (cmd.valid && (cmd.operation == lmsd_pkg::OP_TICK) && display_enable) begin
      if (dwell_sum >= {1'b0, dwell_eff}) begin
        dwell_count_next = '0;
        scan_line_next   = (scan_line == LAST_LINE) ? '0 : scan_line + 1'b1;
      end else begin
        dwell_count_next = dwell_sum[lmsd_pkg::DWELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_line   <= '0;
      dwell_count <= '0;
    end else begin
      scan_line   <= scan_line_next;
      dwell_count <= dwell_count_next;
    end
  end

  // Pick the buffer row read whole in the quarter turns
  always_comb begin
    far_line = LAST_LINE - scan_line;
    row_addr = (rotation_mode == lmsd_pkg::ROT_QUARTER) ? far_line : scan_line;
    row_sel  = rows_next[row_addr];
  end

  // Map the updated buffer to pin levels
  for (genvar k = 0; k < lmsd_pkg::PIN_W; k++) begin : g_pin
    if (k < SIDE) begin : g_used
      localparam int FAR_K = SIDE - 1 - k;
      logic pix;
      always_comb begin
        case (rotation_mode)
          lmsd_pkg::ROT_NONE:    pix = rows_next[k][scan_line];
          lmsd_pkg::ROT_QUARTER: pix = row_sel[k];
          lmsd_pkg::ROT_HALF:    pix = rows_next[FAR_K][far_line];
          default:               pix = row_sel[FAR_K];
        endcase
        if (display_enable) begin
          sel_next[k] = (scan_line == LINE_W'(k)) ? ~active_level : active_level;
          drv_next[k] = pix ? active_level : ~active_level;
        end else begin
          sel_next[k] = active_level;
          drv_next[k] = ~active_level;
        end
      end
    end else begin : g_unused
      assign sel_next[k] = 1'b0;
      assign drv_next[k] = 1'b0;
    end
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.valid;
    end
    if (cmd.valid) begin
      select_pins <= sel_next;
      drive_pins  <= drv_next;
    end
  end

endmodule

FILE: sim/led_matrix_scan_driver_unit_tb.sv
`timescale 1ns / 100ps

module led_matrix_scan_driver_unit_tb;
  import lmsd_pkg::*;

  localparam int N = 8;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 116;

  // Predicts the pin levels for every accepted item and holds them in order
  class pin_scoreboard;
    logic [N-1:0] frame [N];
    int unsigned line_sel;
    int unsigned dwell_ticks;
    logic level;
    logic [ROT_W-1:0] rotation;
    logic [DWELL_W-1:0] dwell;
    logic enable;
    logic [2*PIN_W-1:0] expected_pins [$];
    int error_count;

    function new();
      foreach (frame[i]) frame[i] = '0;
      line_sel = 0;
      dwell_ticks = 0;
      level = 1'b1;
      rotation = ROT_NONE;
      dwell = DWELL_W'(1);
      enable = 1'b0;
      error_count = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_ACTIVE_LEVEL:   level = data[0];
        REG_ROTATION_MODE:  rotation = data[ROT_W-1:0];
        REG_ROW_DWELL:      dwell = data[DWELL_W-1:0];
        REG_DISPLAY_ENABLE: enable = data[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_ACTIVE_LEVEL:   return {31'd0, level};
        REG_ROTATION_MODE:  return {30'd0, rotation};
        REG_ROW_DWELL:      return {24'd0, dwell};
        default:            return {31'd0, enable};
      endcase
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // Apply one item to the frame, record the pins it shows, then step the scan
    function void note_item(logic [OP_W-1:0] op, logic [COORD_W-1:0] fx, fy, lx, ly,
                            logic val, logic whole);
      int x0, x1, y0, y1, x, y, k, eff;
      logic [N-1:0] span, sides, mask;
      logic [PIN_W-1:0] sel, drv;
      logic lit;
      case (op)
        OP_SET_PIXEL: frame[fy][fx] = val;
        OP_RECT: begin
          x0 = int'((fx < lx) ? fx : lx);
          x1 = int'((fx < lx) ? lx : fx);
          y0 = int'((fy < ly) ? fy : ly);
          y1 = int'((fy < ly) ? ly : fy);
          span = '0;
          sides = '0;
          for (x = x0; x <= x1; x++) span[x] = 1'b1;
          sides[x0] = 1'b1;
          sides[x1] = 1'b1;
          for (y = y0; y <= y1; y++) begin
            mask = (whole || y == y0 || y == y1) ? span : sides;
            if (val) frame[y] = frame[y] | mask;
            else frame[y] = frame[y] & ~mask;
          end
        end
        OP_FILL_ALL:  foreach (frame[i]) frame[i] = '1;
        OP_CLEAR_ALL: foreach (frame[i]) frame[i] = '0;
        OP_INVERT:    foreach (frame[i]) frame[i] = ~frame[i];
        default: ;
      endcase

      // Pin levels for the current line after rotation
      for (k = 0; k < N; k++) begin
        if (enable) begin
          sel[k] = (k == line_sel) ? ~level : level;
          case (rotation)
            ROT_NONE:    lit = frame[k][line_sel];
            ROT_QUARTER: lit = frame[N-1-line_sel][k];
            ROT_HALF:    lit = frame[N-1-k][N-1-line_sel];
            default:     lit = frame[line_sel][N-1-k];
          endcase
          drv[k] = lit ? level : ~level;
        end else begin
          sel[k] = level;
          drv[k] = ~level;
        end
      end
      expected_pins.push_back({sel, drv});

      // Advance the scan only on enabled ticks
      if (op == OP_TICK && enable) begin
        eff = (dwell == 0) ? 1 : int'(dwell);
        dwell_ticks++;
        if (dwell_ticks >= eff) begin
          dwell_ticks = 0;
          line_sel = (line_sel == N - 1) ? 0 : line_sel + 1;
        end
      end
    endfunction

    function void check_pins(logic [PIN_W-1:0] sel, logic [PIN_W-1:0] drv);
      logic [2*PIN_W-1:0] want;
      if (expected_pins.size() == 0) begin
        $display("%0t: result with nothing pending: select_pins %h drive_pins %h",
                 $time, sel, drv);
        error_count++;
        return;
      end
      want = expected_pins.pop_front();
      if (sel !== want[2*PIN_W-1:PIN_W]) begin
        $display("%0t: select_pins expected %h actual %h", $time, want[2*PIN_W-1:PIN_W], sel);
        error_count++;
      end
      if (drv !== want[PIN_W-1:0]) begin
        $display("%0t: drive_pins expected %h actual %h", $time, want[PIN_W-1:0], drv);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] operation = '0;
  logic [COORD_W-1:0] first_x = '0;
  logic [COORD_W-1:0] first_y = '0;
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;
  logic pixel_value = 1'b0;
  logic filled = 1'b0;
  logic done;
  logic [PIN_W-1:0] select_pins;
  logic [PIN_W-1:0] drive_pins;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pin_scoreboard sb = new();
  int items_taken = 0;
  int reg_writes = 0;
  int reg_reads = 0;
  int cycle_count = 0;

  int phase_level [RANDOM_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0};
  int phase_rot   [RANDOM_PHASES] = '{1, 2, 3, 0, 3, 2, 1, 0};
  int phase_dwell [RANDOM_PHASES] = '{0, 2, 255, 3, 1, 0, 5, 1};
  int phase_en    [RANDOM_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1};

  led_matrix_scan_driver_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .first_x(first_x),
    .first_y(first_y),
    .last_x(last_x),
    .last_y(last_y),
    .pixel_value(pixel_value),
    .filled(filled),
    .done(done),
    .select_pins(select_pins),
    .drive_pins(drive_pins),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_matrix_scan_driver_unit_tb: done, errors");
      $finish;
    end
  end

  // Watch register accesses, accepted items and results at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          sb.write_reg(paddr[3:2], pwdata);
          reg_writes <= reg_writes + 1;
        end else begin
          if (prdata !== sb.reg_value(paddr[3:2])) begin
            $display("%0t: prdata at %h expected %h actual %h",
                     $time, paddr, sb.reg_value(paddr[3:2]), prdata);
            sb.error_count++;
          end
          reg_reads <= reg_reads + 1;
        end
      end
      if (done) sb.check_pins(select_pins, drive_pins);
      if (start && !busy) begin
        sb.note_item(operation, first_x, first_y, last_x, last_y, pixel_value, filled);
        items_taken <= items_taken + 1;
      end
    end
  end

  // Present one item and hold it until taken
  task automatic send_item(logic [OP_W-1:0] op, logic [COORD_W-1:0] fx, fy, lx, ly,
                           logic val, logic whole);
    int target;
    target = items_taken + 1;
    start = 1'b1;
    operation = op;
    first_x = fx;
    first_y = fy;
    last_x = lx;
    last_y = ly;
    pixel_value = val;
    filled = whole;
    do @(negedge clk); while (items_taken < target);
  endtask

  // Drop start and toggle the fields as noise
  task automatic idle_cycles(int count);
    start = 1'b0;
    repeat (count) begin
      operation = OP_W'($urandom_range(7, 0));
      first_x = COORD_W'($urandom_range(7, 0));
      first_y = COORD_W'($urandom_range(7, 0));
      last_x = COORD_W'($urandom_range(7, 0));
      last_y = COORD_W'($urandom_range(7, 0));
      pixel_value = 1'($urandom_range(1, 0));
      filled = 1'($urandom_range(1, 0));
      @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    int target;
    target = reg_writes + 1;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (reg_writes < target);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic reg_read(logic [REG_IDX_W-1:0] idx);
    int target;
    target = reg_reads + 1;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (reg_reads < target);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Wait for idle, then load all registers with junk in the unused bits and read back
  task automatic configure(int lvl, int rot, int dw, int en);
    drain_results();
    reg_write(REG_ACTIVE_LEVEL, ($urandom & 32'hFFFF_FFFE) | lvl);
    reg_write(REG_ROTATION_MODE, ($urandom & 32'hFFFF_FFFC) | rot);
    reg_write(REG_ROW_DWELL, ($urandom & 32'hFFFF_FF00) | dw);
    reg_write(REG_DISPLAY_ENABLE, ($urandom & 32'hFFFF_FFFE) | en);
    reg_read(REG_ACTIVE_LEVEL);
    reg_read(REG_ROTATION_MODE);
    reg_read(REG_ROW_DWELL);
    reg_read(REG_DISPLAY_ENABLE);
  endtask

  task automatic random_item();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(99, 0);
    if (r < 35) op = OP_TICK;
    else if (r < 55) op = OP_SET_PIXEL;
    else if (r < 80) op = OP_RECT;
    else if (r < 85) op = OP_FILL_ALL;
    else if (r < 90) op = OP_CLEAR_ALL;
    else if (r < 96) op = OP_INVERT;
    else if (r < 98) op = OP_SPARE_A;
    else op = OP_SPARE_B;
    send_item(op, COORD_W'($urandom_range(7, 0)), COORD_W'($urandom_range(7, 0)),
              COORD_W'($urandom_range(7, 0)), COORD_W'($urandom_range(7, 0)),
              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
  endtask

  initial begin
    int p, i;
    bit calm;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Display off after reset: pins held off, ticks do not scan
    send_item(OP_SET_PIXEL, 0, 0, 0, 0, 1'b1, 1'b0);
    send_item(OP_TICK, 0, 0, 0, 0, 1'b0, 1'b0);
    send_item(OP_SPARE_A, 7, 7, 7, 7, 1'b1, 1'b1);

    // Enable with zero dwell, which acts as one tick per line
    configure(1, ROT_NONE, 0, 1);
    send_item(OP_SET_PIXEL, 7, 7, 0, 0, 1'b1, 1'b0);
    send_item(OP_SET_PIXEL, 0, 7, 0, 0, 1'b1, 1'b0);
    send_item(OP_SET_PIXEL, 7, 0, 0, 0, 1'b1, 1'b0);
    send_item(OP_SET_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0);
    send_item(OP_RECT, 7, 7, 0, 0, 1'b1, 1'b1);
    send_item(OP_RECT, 1, 1, 6, 6, 1'b0, 1'b0);
    // Narrow boxes: a column, a row with swapped corners, a single pixel, a short filled row
    send_item(OP_RECT, 5, 2, 5, 6, 1'b0, 1'b0);
    send_item(OP_RECT, 6, 3, 2, 3, 1'b1, 1'b0);
    send_item(OP_RECT, 4, 4, 4, 4, 1'b0, 1'b0);
    send_item(OP_RECT, 2, 5, 3, 5, 1'b0, 1'b1);
    send_item(OP_INVERT, 0, 0, 0, 0, 1'b0, 1'b0);
    // Scan through all lines and wrap
    repeat (9) send_item(OP_TICK, 0, 0, 0, 0, 1'b0, 1'b0);
    send_item(OP_CLEAR_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
    send_item(OP_FILL_ALL, 0, 0, 0, 0, 1'b0, 1'b0);
    send_item(OP_SPARE_B, 3, 3, 3, 3, 1'b1, 1'b1);

    // Random phases, each under its own register setting
    for (p = 0; p < RANDOM_PHASES; p++) begin
      configure(phase_level[p], phase_rot[p], phase_dwell[p], phase_en[p]);
      calm = (p == RANDOM_PHASES - 1) || ($urandom_range(3, 0) == 0);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (!calm && $urandom_range(5, 0) == 0) idle_cycles($urandom_range(14, 1));
        random_item();
      end
    end

    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.error_count == 0) begin
      $display("led_matrix_scan_driver_unit_tb: done, clean");
    end else begin
      $display("led_matrix_scan_driver_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lmsd_pkg.sv
hdl/lmsd_fbuf.sv
hdl/led_matrix_scan_driver_unit.sv
sim/led_matrix_scan_driver_unit_tb.sv
